// File: hw/rtl/lzwe_pkg.sv
`default_nettype none

package lzwe_pkg;

  localparam int SYM_W    = 7;
  localparam int LETTER_W = 5;
  localparam int CODE_W   = 12;
  localparam int NFC_W    = 13;
  localparam int KEY_W    = CODE_W + LETTER_W;
  localparam int CELLS    = 8;

  localparam logic [SYM_W-1:0] ASCII_A = 7'd65;
  localparam logic [SYM_W-1:0] ASCII_Z = 7'd90;

  localparam logic [LETTER_W-1:0] LETTER_FIRST = 5'd1;
  localparam logic [LETTER_W-1:0] LETTER_LAST  = 5'd26;

  localparam logic [NFC_W-1:0] FIRST_CODE  = 13'd27;
  localparam logic [NFC_W-1:0] CODE_SPACE  = 13'd4096;
  localparam logic [NFC_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } chain_t;

  typedef struct packed {
    logic probe;
    logic flush;
  } cell_ctl_t;

  function automatic logic [LETTER_W-1:0] letter_code(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] offs;
    offs = sym - ASCII_A;
    if (sym < ASCII_A) begin
      return LETTER_FIRST;
    end else if (sym > ASCII_Z) begin
      return LETTER_LAST;
    end else begin
      return LETTER_W'(offs) + LETTER_FIRST;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lzwe_cell.sv
`default_nettype none

module lzwe_cell
  import lzwe_pkg::*;
#(
  parameter int ROWS  = 512,
  parameter int IDX   = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctl_t                ctl,
  input  wire logic [$clog2(ROWS)-1:0]  rd_row,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(ROWS)-1:0]  wr_row,
  input  wire logic [KEY_W-1:0]         wr_data,
  input  wire logic [KEY_W-1:0]         key,
  input  wire logic [NFC_W-1:0]         nfc,
  input  wire chain_t                   chain_in,
  output chain_t                        chain_out
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int LG    = $clog2(CELLS);
  localparam int CW    = ROW_W + LG;

  logic [KEY_W-1:0] mem [ROWS];
  logic [KEY_W-1:0] rd_data_r;
  logic [ROW_W-1:0] row_q_r;
  logic             probe_r;
  chain_t           chain_r;
  chain_t           chain_nxt;
  logic [CW-1:0]    cell_code;
  logic [NFC_W-1:0] code_ext;
  logic             match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    rd_data_r <= mem[rd_row];
    row_q_r   <= rd_row;
  end

  assign cell_code = {row_q_r, LG'(IDX)};
  assign code_ext  = NFC_W'(cell_code);
  assign match     = probe_r && (code_ext >= FIRST_CODE) && (code_ext < nfc) &&
                     (rd_data_r == key);

  always_comb begin
    if (match) begin
      chain_nxt.hit  = 1'b1;
      chain_nxt.code = CODE_W'(cell_code);
    end else begin
      chain_nxt = chain_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
      chain_r <= '0;
    end else begin
      probe_r <= ctl.probe && !ctl.flush;
      if (ctl.flush) begin
        chain_r <= '0;
      end else begin
        chain_r <= chain_nxt;
      end
    end
  end

  assign chain_out = chain_r;

endmodule

`default_nettype wire

// File: hw/rtl/lzw_encoder.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_symbol, in_last_symbol
// out_      output     out_valid / out_stall  out_code, out_last_code
// cfg_      input      cfg_valid / cfg_ready  cfg_dict_limit
//
// A letter that opens a message only becomes the prefix; else the row scan reads R rows,
// from the row of code 27 to the row of next_free_code - 1
// (about (next_free_code - 27) / CELLS), and the hit chain then drains; a hit ends the search early.
// A last letter adds a step for the final code; a waiting result holds the encoder in stall.
// Reset clears control state only; the dictionary memories need no clearing.

module lzw_encoder
  import lzwe_pkg::*;
#(
  parameter int DICT_ENTRIES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SYM_W-1:0]    in_symbol,
  input  wire logic                in_last_symbol,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CODE_W-1:0]        out_code,
  output logic                     out_last_code,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [NFC_W-1:0]    cfg_dict_limit
);

  localparam int DEPTH   = (DICT_ENTRIES < 4096) ? DICT_ENTRIES : 4096;
  localparam int LG      = $clog2(CELLS);
  localparam int ROWS    = (DEPTH + CELLS - 1) / CELLS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int DRAIN_W = $clog2(CELLS + 1);

  localparam logic [NFC_W-1:0] DEPTH_CODE = NFC_W'(DEPTH);
  localparam logic [ROW_W-1:0] FIRST_ROW  = ROW_W'(27 / CELLS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MISS  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [DRAIN_W-1:0]  drain_r, drain_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                last_r, last_nxt;
  logic [CODE_W-1:0]   prefix_r, prefix_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic [NFC_W-1:0]    nfc_r, nfc_nxt;
  logic [NFC_W-1:0]    limit_r, limit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic                out_last_r, out_last_nxt;

  logic [LETTER_W-1:0] in_letter;
  logic [NFC_W-1:0]    nfc_m1;
  logic [ROW_W-1:0]    last_row;
  logic [NFC_W-1:0]    eff_limit;
  logic                out_free;
  logic                do_write;
  cell_ctl_t           ctl;
  chain_t              chain [CELLS+1];
  logic                end_hit;

  assign in_letter = letter_code(in_symbol);
  assign nfc_m1    = nfc_r - 13'd1;
  assign last_row  = nfc_m1[LG +: ROW_W];
  assign eff_limit = (limit_r < DEPTH_CODE) ? limit_r : DEPTH_CODE;
  assign out_free  = !out_valid_r || !out_stall;
  assign end_hit   = chain[CELLS].hit;
  assign chain[0]  = '0;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    key_nxt       = key_r;
    letter_nxt    = letter_r;
    last_nxt      = last_r;
    prefix_nxt    = prefix_r;
    pvalid_nxt    = pvalid_r;
    nfc_nxt       = nfc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    do_write      = 1'b0;
    ctl.probe     = 1'b0;
    ctl.flush     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          letter_nxt = in_letter;
          last_nxt   = in_last_symbol;
          key_nxt    = {prefix_r, in_letter};
          if (!pvalid_r) begin
            prefix_nxt = CODE_W'(in_letter);
            pvalid_nxt = 1'b1;
            if (in_last_symbol) begin
              state_nxt = ST_FIN;
            end
          end else if (nfc_r == FIRST_CODE) begin
            state_nxt = ST_MISS;
          end else begin
            row_nxt   = FIRST_ROW;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (end_hit) begin
          ctl.flush  = 1'b1;
          prefix_nxt = chain[CELLS].code;
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end else begin
          ctl.probe = 1'b1;
          if (row_r == last_row) begin
            drain_nxt = DRAIN_W'(CELLS);
            state_nxt = ST_DRAIN;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (end_hit) begin
          ctl.flush  = 1'b1;
          prefix_nxt = chain[CELLS].code;
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end else if (drain_r == '0) begin
          state_nxt = ST_MISS;
        end else begin
          drain_nxt = drain_r - 1'b1;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = prefix_r;
          out_last_nxt  = 1'b0;
          if (nfc_r < eff_limit) begin
            do_write = 1'b1;
            nfc_nxt  = nfc_r + 13'd1;
          end
          prefix_nxt = CODE_W'(letter_r);
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = prefix_r;
          out_last_nxt  = 1'b1;
          prefix_nxt    = '0;
          pvalid_nxt    = 1'b0;
          nfc_nxt       = FIRST_CODE;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign limit_nxt = cfg_valid ? cfg_dict_limit : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prefix_r    <= '0;
      pvalid_r    <= 1'b0;
      nfc_r       <= FIRST_CODE;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      pvalid_r    <= pvalid_nxt;
      nfc_r       <= nfc_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    drain_r    <= drain_nxt;
    key_r      <= key_nxt;
    letter_r   <= letter_nxt;
    last_r     <= last_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    lzwe_cell #(
      .ROWS  (ROWS),
      .IDX   (j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rd_row    (row_r),
      .wr_en     (do_write && (nfc_r[LG-1:0] == LG'(j))),
      .wr_row    (nfc_r[LG +: ROW_W]),
      .wr_data   (key_r),
      .key       (key_r),
      .nfc       (nfc_r),
      .chain_in  (chain[j]),
      .chain_out (chain[j+1])
    );
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_code      = out_code_r;
  assign out_last_code = out_last_r;
  assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire
